// ----- rtl/core/tdfe_pkg.sv -----
package tdfe_pkg;

  localparam int MAX_ROUNDS  = 16;
  localparam int BLOCK_W     = 12;
  localparam int HALF_W      = BLOCK_W / 2;
  localparam int EXP_W       = 8;
  localparam int SBOX_OUT_W  = 3;
  localparam int NIB_W       = EXP_W / 2;
  localparam int TDATA_W     = ((BLOCK_W + 7) / 8) * 8;
  localparam int KEY_W       = 8;
  localparam int COUNT_W     = 5;
  localparam int CFG_DATA_W  = (KEY_W > COUNT_W) ? KEY_W : COUNT_W;
  localparam int CFG_INDEX_W = 1;
  localparam int ROUND_IDX_W = $clog2(MAX_ROUNDS + 1);
  localparam int CMP_W       = (ROUND_IDX_W > COUNT_W) ? ROUND_IDX_W : COUNT_W;

  localparam logic [KEY_W-1:0]   KEY_RESET   = KEY_W'(8'hAA);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_KEY   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT = CFG_INDEX_W'(1);

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [HALF_W-1:0]  half_t;

  // Per-cell round control: whether this cell applies its round, and the key
  typedef struct packed {
    logic             round_on;
    logic [KEY_W-1:0] key;
  } round_ctl_t;

  localparam logic [2:0] EXPAND_SEL [EXP_W] = '{
    3'd0, 3'd1, 3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd5
  };

  localparam logic [SBOX_OUT_W-1:0] SBOX_HI [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };

  localparam logic [SBOX_OUT_W-1:0] SBOX_LO [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  // Expand the right half by bit selection (first entry lands in the MSB),
  // mix in the key, then substitute each nibble.
  function automatic half_t feistel_f(input half_t r, input logic [KEY_W-1:0] key);
    logic [EXP_W-1:0] e;
    logic [EXP_W-1:0] x;
    begin
      for (int j = 0; j < EXP_W; j++) begin
        e[EXP_W-1-j] = r[HALF_W-1-int'(EXPAND_SEL[j])];
      end
      x = e ^ key;
      feistel_f = {SBOX_HI[x[EXP_W-1:NIB_W]], SBOX_LO[x[NIB_W-1:0]]};
    end
  endfunction

endpackage

// ----- rtl/core/tdfe_cell.sv -----
module tdfe_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  tdfe_pkg::round_ctl_t   ctl,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tdfe_pkg::block_t       in_block,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tdfe_pkg::block_t       out_block
);

  logic             valid;
  tdfe_pkg::block_t block;
  tdfe_pkg::block_t block_next;
  tdfe_pkg::half_t  left_in;
  tdfe_pkg::half_t  right_in;

  assign left_in  = in_block[tdfe_pkg::BLOCK_W-1:tdfe_pkg::HALF_W];
  assign right_in = in_block[tdfe_pkg::HALF_W-1:0];

  // If round_on, swap halves and fold feistel_f into the new right half
  always_comb begin
    if (ctl.round_on) begin
      block_next = {right_in, left_in ^ tdfe_pkg::feistel_f(right_in, ctl.key)};
    end else begin
      block_next = in_block;
    end
  end

  // Take a new transaction whenever the slot is empty or is being emptied
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      block <= block_next;
    end
  end

  assign out_valid = valid;
  assign out_block = block;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid)
    else $error("cell dropped a stalled transaction");

  a_hold_block: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> $stable(block))
    else $error("cell payload changed while stalled");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !ctl.round_on |=> block == $past(in_block))
    else $error("inactive cell altered the block");

  a_round: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && ctl.round_on
      |=> block[tdfe_pkg::BLOCK_W-1:tdfe_pkg::HALF_W] == $past(right_in))
    else $error("active cell did not swap halves");

endmodule

// ----- rtl/core/toy_des_feistel_encrypt_unit.sv -----
// Toy DES-style Feistel encryptor for 12-bit blocks. One block is taken per
// cycle while the first cell has room, and each block passes through a row
// of 16 round cells, one register each. A cell whose round number is at or
// above round_count only carries the block along. round_count above 16 acts
// as 16, and zero returns the plaintext. Every cell has its own slot, so gaps
// in the row close up under output back-pressure and input is still taken
// while a result waits. Write round_key and round_count only while no block
// is in flight.
module toy_des_feistel_encrypt_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tdfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tdfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tdfe_pkg::TDATA_W-1:0]       s_tdata,  // [11:0] plain_block
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tdfe_pkg::TDATA_W-1:0]       m_tdata   // [11:0] cipher_block
);

  logic [tdfe_pkg::KEY_W-1:0]   round_key;
  logic [tdfe_pkg::COUNT_W-1:0] round_count;
  logic [tdfe_pkg::CMP_W-1:0]   rounds_eff;

  logic             chain_valid [tdfe_pkg::MAX_ROUNDS+1];
  logic             chain_ready [tdfe_pkg::MAX_ROUNDS+1];
  tdfe_pkg::block_t chain_block [tdfe_pkg::MAX_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      round_key   <= tdfe_pkg::KEY_RESET;
      round_count <= tdfe_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tdfe_pkg::REG_ROUND_KEY:   round_key   <= cfg_data[tdfe_pkg::KEY_W-1:0];
        tdfe_pkg::REG_ROUND_COUNT: round_count <= cfg_data[tdfe_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the count at the length of the row
  always_comb begin
    if (tdfe_pkg::CMP_W'(round_count) > tdfe_pkg::CMP_W'(tdfe_pkg::MAX_ROUNDS)) begin
      rounds_eff = tdfe_pkg::CMP_W'(tdfe_pkg::MAX_ROUNDS);
    end else begin
      rounds_eff = tdfe_pkg::CMP_W'(round_count);
    end
  end

  assign chain_valid[0] = s_tvalid;
  assign chain_block[0] = s_tdata[tdfe_pkg::BLOCK_W-1:0];
  assign s_tready       = chain_ready[0];

  for (genvar k = 0; k < tdfe_pkg::MAX_ROUNDS; k++) begin : g_cell
    tdfe_pkg::round_ctl_t ctl;

    assign ctl.round_on = tdfe_pkg::CMP_W'(k) < rounds_eff;
    assign ctl.key      = round_key;

    tdfe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_block  (chain_block[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_block (chain_block[k+1])
    );
  end

  assign chain_ready[tdfe_pkg::MAX_ROUNDS] = m_tready;
  assign m_tvalid = chain_valid[tdfe_pkg::MAX_ROUNDS];
  assign m_tdata  = tdfe_pkg::TDATA_W'(chain_block[tdfe_pkg::MAX_ROUNDS]);

endmodule
